FILE: rtl/hpc_pkg.sv
// Package for the homogeneous plane polygon clipper.
// Holds the payload, vector and sequencer types and the plane distance helpers.
// Depends on nothing; every other file of the block imports it.
package hpc_pkg;

    localparam int DIST_W = 34;

    localparam logic [1:0] CFG_CLIP_AXIS   = 2'd0;
    localparam logic [1:0] CFG_NEGATE_SIDE = 2'd1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_W = 2'd3;

    typedef logic signed [31:0] t_coord;
    typedef logic [3:0][31:0]   t_vec;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_w;
        logic               last_vertex;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               out_last;
        logic               polygon_empty;
    } t_result;

    typedef struct packed {
        logic              start;
        logic [DIST_W-1:0] num;
        logic [DIST_W-1:0] den;
    } t_div_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIST,
        S_DIV,
        S_MUL,
        S_ACC,
        S_PUSHI,
        S_PUSHB,
        S_NEXT,
        S_FINAL
    } t_state;

    function automatic t_coord coord_of(input t_vec v, input logic [1:0] idx);
        t_coord c;
        case (idx)
            AXIS_X:  c = v[0];
            AXIS_Y:  c = v[1];
            AXIS_Z:  c = v[2];
            AXIS_W:  c = v[3];
            default: c = v[3];
        endcase
        return c;
    endfunction

    // Distance to the plane, w - s*coord; non-negative means inside.
    function automatic logic signed [DIST_W-1:0] plane_dist(input t_vec v,
                                                           input logic [1:0] axis,
                                                           input logic neg);
        logic signed [DIST_W-1:0] c;
        logic signed [DIST_W-1:0] w;
        c = DIST_W'(coord_of(v, axis));
        w = DIST_W'($signed(v[3]));
        if (neg) begin
            c = -c;
        end
        return w - c;
    endfunction

    function automatic t_coord sat32(input logic signed [DIST_W:0] v);
        t_coord r;
        if (v > $signed((DIST_W+1)'(32'sh7FFF_FFFF))) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < $signed(-(DIST_W+1)'(33'sh0_8000_0000))) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic t_vec vec_of(input t_in_item it);
        t_vec v;
        v[0] = it.pos_x;
        v[1] = it.pos_y;
        v[2] = it.pos_z;
        v[3] = it.pos_w;
        return v;
    endfunction

endpackage

FILE: rtl/hpc_div.sv
// Serial restoring divider for the crossing parameter t = |dP| / |dP - dC|.
// One quotient bit a cycle, FRAC_BITS+1 quotient bits, rounding to nearest built in.
// Depends on hpc_pkg.
module hpc_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hpc_pkg::t_div_req    i_req,
    output logic                 o_done,
    output logic [FRAC_BITS:0]   o_quo
);
    import hpc_pkg::*;

    localparam int Q  = FRAC_BITS + 1;
    localparam int NW = DIST_W + Q;
    localparam int CW = $clog2(Q + 1);

    logic [DIST_W-1:0] r_rem, n_rem;
    logic [DIST_W-1:0] r_den;
    logic [Q-1:0]      r_quo, n_quo;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    logic [NW-1:0]     dividend;
    logic [DIST_W:0]   rem2;
    logic [DIST_W:0]   diff;
    logic              ge;

    // Half the divisor is added so that the truncating quotient rounds half up.
    assign dividend = (NW'(i_req.num) << FRAC_BITS) + NW'(i_req.den >> 1);
    assign rem2     = {r_rem, r_quo[Q-1]};
    assign diff     = rem2 - {1'b0, r_den};
    assign ge       = (rem2 >= {1'b0, r_den});

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = dividend[NW-1:Q];
            n_quo  = dividend[Q-1:0];
            n_cnt  = CW'(Q);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? diff[DIST_W-1:0] : rem2[DIST_W-1:0];
            n_quo = {r_quo[Q-2:0], ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_req.start) begin
            r_den <= i_req.den;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: rtl/hpc_lerp.sv
// Shared interpolation unit: one coordinate of P + (C - P) * t a request.
// The product is registered; rounding and saturation follow in the next cycle.
// Depends on hpc_pkg.
module hpc_lerp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_go,
    input  hpc_pkg::t_coord       i_p,
    input  hpc_pkg::t_coord       i_c,
    input  logic [FRAC_BITS:0]    i_t,
    output hpc_pkg::t_coord       o_res
);
    import hpc_pkg::*;

    localparam int PW = FRAC_BITS + DIST_W + 1;

    logic signed [32:0]     diff;
    logic signed [PW-1:0]   diff_ext;
    logic signed [PW-1:0]   t_ext;
    logic signed [PW-1:0]   r_prod;
    t_coord                 r_p;
    logic signed [PW-1:0]   x;
    logic signed [PW-1:0]   q;
    logic signed [DIST_W:0] sum;

    assign diff     = $signed({i_c[31], i_c}) - $signed({i_p[31], i_p});
    assign diff_ext = PW'(diff);
    assign t_ext    = $signed(PW'(i_t));

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_prod <= diff_ext * t_ext;
            r_p    <= i_p;
        end
    end

    // An arithmetic shift after adding one half gives round half up.
    assign x     = r_prod + (PW'(1) << (FRAC_BITS - 1));
    assign q     = x >>> FRAC_BITS;
    assign sum   = (DIST_W+1)'(r_p) + q[DIST_W:0];
    assign o_res = sat32(sum);

endmodule

FILE: rtl/homogeneous_plane_polygon_clip.sv
// Top level of the homogeneous plane polygon clipper.
// Holds the sequencer, vertex store and output register; uses hpc_div and hpc_lerp.
// Depends on hpc_pkg.
//
// Usage: vertices of a polygon enter in order on the input channel
// (i_in_valid, o_in_stall, i_in_data), the last one marked by last_vertex.
// Clipped vertices leave on the output channel (o_out_valid, i_out_stall,
// o_out_data); the final one of each polygon carries out_last, and a polygon
// clipped away entirely gives a single result with polygon_empty set.
// Each result is held back by one, so the order is that of the plain clipper
// rotated by one edge.
// One vertex is worked on at a time. The first vertex of a polygon is only
// stored, unless it is also the last; a later vertex whose edge does not cross
// the plane has its distances checked and its end pushed if inside, one whose
// edge crosses waits for the serial divider and then makes four passes through
// the one multiplier, one per coordinate, before the pushes.
// A last vertex runs its closing edge too.
// A request on the output waits in its register while the receiver stalls;
// the sequencer only waits when it must push a second result behind it.
// Reset clears the polygon state and the registers clip_axis and
// negate_side; the stored vertices need no clearing.
module homogeneous_plane_polygon_clip #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [1:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hpc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hpc_pkg::t_result   o_out_data
);
    import hpc_pkg::*;

    t_state r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic       r_neg, n_neg;
    logic       r_in_poly, n_in_poly;
    logic       r_emitted, n_emitted;
    logic       r_ov, n_ov;
    logic       r_last, n_last;
    logic       r_edge, n_edge;
    logic [1:0] r_k, n_k;

    t_vec    r_cur, n_cur, r_prev, n_prev, r_first, n_first;
    t_vec    r_hold, n_hold, r_iv, n_iv;
    t_result r_out, n_out;
    logic    r_inb, n_inb;
    logic [FRAC_BITS:0] r_t, n_t;

    t_vec       a_v, b_v, push_v;
    logic signed [DIST_W-1:0] da, db;
    logic signed [DIST_W:0]   dd;
    logic       in_acc, out_free, push_req, lerp_go;
    t_div_req   div_req;
    logic       div_done;
    logic [FRAC_BITS:0] div_quo;
    t_coord     lerp_res;

    hpc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    hpc_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
        .i_clk (i_clk),
        .i_go  (lerp_go),
        .i_p   (coord_of(a_v, r_k)),
        .i_c   (coord_of(b_v, r_k)),
        .i_t   (r_t),
        .o_res (lerp_res)
    );

    // The closing edge runs from the current vertex back to the first.
    assign a_v = r_edge ? r_cur : r_prev;
    assign b_v = r_edge ? r_first : r_cur;
    assign da  = plane_dist(a_v, r_axis, r_neg);
    assign db  = plane_dist(b_v, r_axis, r_neg);
    assign dd  = (DIST_W+1)'(da) - (DIST_W+1)'(db);

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_ov || !i_out_stall;

    always_comb begin
        n_state   = r_state;
        n_axis    = r_axis;
        n_neg     = r_neg;
        n_in_poly = r_in_poly;
        n_emitted = r_emitted;
        n_ov      = r_ov && i_out_stall;
        n_last    = r_last;
        n_edge    = r_edge;
        n_k       = r_k;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_first   = r_first;
        n_hold    = r_hold;
        n_iv      = r_iv;
        n_out     = r_out;
        n_inb     = r_inb;
        n_t       = r_t;
        push_req  = 1'b0;
        push_v    = r_iv;
        lerp_go   = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = da[DIST_W-1] ? DIST_W'(-da) : DIST_W'(da);
        div_req.den   = dd[DIST_W] ? DIST_W'(-dd) : DIST_W'(dd);

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLIP_AXIS:   n_axis = i_cfg_wdata;
                CFG_NEGATE_SIDE: n_neg  = i_cfg_wdata[0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cur  = vec_of(i_in_data);
                    n_last = i_in_data.last_vertex;
                    n_edge = 1'b0;
                    if (!r_in_poly) begin
                        n_first   = vec_of(i_in_data);
                        n_prev    = vec_of(i_in_data);
                        n_in_poly = 1'b1;
                        n_emitted = 1'b0;
                        if (i_in_data.last_vertex) begin
                            n_edge  = 1'b1;
                            n_state = S_DIST;
                        end
                    end else begin
                        n_state = S_DIST;
                    end
                end
            end
            S_DIST: begin
                n_inb = !db[DIST_W-1];
                if (da[DIST_W-1] != db[DIST_W-1]) begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                end else begin
                    n_state = S_PUSHB;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_t     = div_quo;
                    n_k     = 2'd0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                lerp_go = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                n_iv[r_k] = lerp_res;
                if (r_k == 2'd3) begin
                    n_state = S_PUSHI;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_PUSHI: begin
                push_req = 1'b1;
                push_v   = r_iv;
                if (!r_emitted || out_free) begin
                    n_state = r_inb ? S_PUSHB : S_NEXT;
                end
            end
            S_PUSHB: begin
                push_req = r_inb;
                push_v   = b_v;
                if (!r_inb || !r_emitted || out_free) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_last && !r_edge) begin
                    n_edge  = 1'b1;
                    n_state = S_DIST;
                end else if (r_last) begin
                    n_state = S_FINAL;
                end else begin
                    n_prev  = r_cur;
                    n_state = S_IDLE;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_ov                = 1'b1;
                    n_out.out_x         = r_emitted ? r_hold[0] : '0;
                    n_out.out_y         = r_emitted ? r_hold[1] : '0;
                    n_out.out_z         = r_emitted ? r_hold[2] : '0;
                    n_out.out_w         = r_emitted ? r_hold[3] : '0;
                    n_out.out_last      = 1'b1;
                    n_out.polygon_empty = !r_emitted;
                    n_in_poly           = 1'b0;
                    n_emitted           = 1'b0;
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // A new vertex goes into the hold register and pushes the old one out.
        if (push_req && (!r_emitted || out_free)) begin
            if (r_emitted) begin
                n_ov                = 1'b1;
                n_out.out_x         = r_hold[0];
                n_out.out_y         = r_hold[1];
                n_out.out_z         = r_hold[2];
                n_out.out_w         = r_hold[3];
                n_out.out_last      = 1'b0;
                n_out.polygon_empty = 1'b0;
            end
            n_hold    = push_v;
            n_emitted = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_axis    <= 2'd0;
            r_neg     <= 1'b0;
            r_in_poly <= 1'b0;
            r_emitted <= 1'b0;
            r_ov      <= 1'b0;
            r_last    <= 1'b0;
            r_edge    <= 1'b0;
            r_k       <= 2'd0;
        end else begin
            r_state   <= n_state;
            r_axis    <= n_axis;
            r_neg     <= n_neg;
            r_in_poly <= n_in_poly;
            r_emitted <= n_emitted;
            r_ov      <= n_ov;
            r_last    <= n_last;
            r_edge    <= n_edge;
            r_k       <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_first <= n_first;
        r_hold  <= n_hold;
        r_iv    <= n_iv;
        r_out   <= n_out;
        r_inb   <= n_inb;
        r_t     <= n_t;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.polygon_empty) |-> o_out_data.out_last)
        else $error("empty polygon result without out_last");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.polygon_empty) |->
            (o_out_data.out_x == 0 && o_out_data.out_y == 0 &&
             o_out_data.out_z == 0 && o_out_data.out_w == 0))
        else $error("empty polygon result with non-zero coordinates");

    a_poly_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_in_poly && !i_in_data.last_vertex) |=> r_in_poly)
        else $error("polygon not opened by its first vertex");

endmodule
